/* hw/rtl/triangle_tangent_bitangent_defines.svh */
// Assertion macros included by triangle_tangent_bitangent.
`ifndef TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH

// Checked at every rising edge of clk while reset is released.
`define TTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define TTB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ttb_pkg.sv */
package ttb_pkg;

	localparam int COORD_W = 32;
	localparam int DELTA_W = COORD_W + 1;
	localparam int PROD_W = 2 * DELTA_W;
	localparam int NUM_W = PROD_W + 1;
	localparam int MUL_OPS = 14;
	localparam int COMPONENTS = 6;

	localparam logic [COORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] tex_u;
		logic signed [COORD_W-1:0] tex_v;
	} corner_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] tangent_x;
		logic signed [COORD_W-1:0] tangent_y;
		logic signed [COORD_W-1:0] tangent_z;
		logic signed [COORD_W-1:0] bitangent_x;
		logic signed [COORD_W-1:0] bitangent_y;
		logic signed [COORD_W-1:0] bitangent_z;
		logic degenerate;
		logic clipped;
	} result_t;

	typedef struct packed {
		logic done;
		logic clip;
		logic [COORD_W-1:0] quo;
	} div_status_t;

endpackage

/* hw/rtl/ttb_stream_if.sv */
interface ttb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ttb_mul.sv */
module ttb_mul (
	input logic clk,
	input logic signed [ttb_pkg::DELTA_W-1:0] a,
	input logic signed [ttb_pkg::DELTA_W-1:0] b,
	output logic signed [ttb_pkg::PROD_W-1:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

/* hw/rtl/ttb_div.sv */
module ttb_div #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [ttb_pkg::NUM_W-1:0] num,
	input logic signed [ttb_pkg::NUM_W-1:0] den,
	output ttb_pkg::div_status_t status
);

	localparam int NW = ttb_pkg::NUM_W + FRAC_BITS;
	localparam int RW = ttb_pkg::NUM_W + 1;
	localparam int QW = ttb_pkg::COORD_W;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_CHK = 2'd1;
	localparam logic [1:0] D_STEP = 2'd2;
	localparam logic [1:0] D_FIN = 2'd3;

	logic [1:0] st_q;
	logic [RW-1:0] r_q;
	logic [ttb_pkg::NUM_W-1:0] d_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] qa_q;
	logic [4:0] k_q;
	logic neg_q;
	logic done_q;
	logic clip_q;
	logic [QW-1:0] quo_q;

	logic [ttb_pkg::NUM_W-1:0] an;
	logic [ttb_pkg::NUM_W-1:0] ad;
	logic [NW-1:0] nsh;
	logic [RW-1:0] cmp_in;
	logic [RW-1:0] diff;
	logic ge;

	always_comb begin
		an = num[ttb_pkg::NUM_W-1] ? ttb_pkg::NUM_W'(-num) : ttb_pkg::NUM_W'(num);
		ad = den[ttb_pkg::NUM_W-1] ? ttb_pkg::NUM_W'(-den) : ttb_pkg::NUM_W'(den);
		nsh = {an, {FRAC_BITS{1'b0}}};
		cmp_in = (st_q == D_CHK) ? r_q : {r_q[RW-2:0], lo_q[QW-1]};
		ge = cmp_in >= {1'b0, d_q};
		diff = cmp_in - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q <= D_CHK;
					end
				end
				D_CHK: begin
					st_q <= ge ? D_FIN : D_STEP;
				end
				D_STEP: begin
					if (k_q == 5'd0) begin
						st_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q <= 1'b1;
					st_q <= D_IDLE;
				end
				default: begin
					st_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (start) begin
					r_q <= RW'(nsh[NW-1:QW]);
					lo_q <= nsh[QW-1:0];
					d_q <= ad;
					neg_q <= num[ttb_pkg::NUM_W-1] ^ den[ttb_pkg::NUM_W-1];
				end
			end
			D_CHK: begin
				if (ge) begin
					qa_q <= '1;
				end else begin
					qa_q <= '0;
					k_q <= 5'd31;
				end
			end
			D_STEP: begin
				r_q <= ge ? diff : cmp_in;
				lo_q <= {lo_q[QW-2:0], 1'b0};
				qa_q <= {qa_q[QW-2:0], ge};
				k_q <= k_q - 5'd1;
			end
			D_FIN: begin
				if (neg_q) begin
					if (qa_q > ttb_pkg::Q_MIN) begin
						quo_q <= ttb_pkg::Q_MIN;
						clip_q <= 1'b1;
					end else begin
						quo_q <= -qa_q;
						clip_q <= 1'b0;
					end
				end else begin
					if (qa_q > ttb_pkg::Q_MAX) begin
						quo_q <= ttb_pkg::Q_MAX;
						clip_q <= 1'b1;
					end else begin
						quo_q <= qa_q;
						clip_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign status.done = done_q;
	assign status.clip = clip_q;
	assign status.quo = quo_q;

endmodule

/* hw/rtl/triangle_tangent_bitangent.sv */
// Channel   Direction  Payload
// corner    in         pos_x, pos_y, pos_z, tex_u, tex_v (signed Q16.16)
// result    out        tangent_x/y/z, bitangent_x/y/z, degenerate, clipped
//
// The first and second corner of a triangle are only stored. The third holds the block
// for the multiplies and six divides (a divide ends early when its quotient saturates
// outright); a degenerate triangle skips the divides.
// The corner request is refused from the third corner until its result is taken.
// Reset clears the corner count and all sequencer state; stored corners are kept.
module triangle_tangent_bitangent #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	ttb_stream_if.sink corner,
	ttb_stream_if.source result
);

	`include "triangle_tangent_bitangent_defines.svh"

	localparam int DW = ttb_pkg::DELTA_W;
	localparam int NW = ttb_pkg::NUM_W;
	localparam int CW = ttb_pkg::COORD_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	localparam logic [3:0] LAST_OP = 4'(ttb_pkg::MUL_OPS - 1);
	localparam logic [2:0] LAST_COMP = 3'(ttb_pkg::COMPONENTS - 1);

	logic [1:0] state_q;
	logic [1:0] cnt_q;
	logic [1:0] cc;

	logic [CW-1:0] p1_q [3];
	logic [CW-1:0] p2_q [3];
	logic [CW-1:0] t1_q [2];
	logic [CW-1:0] t2_q [2];

	logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DW-1:0] e1_q [3];
	logic signed [DW-1:0] e2_q [3];

	logic [3:0] mi_q;
	logic issue;
	logic p_vld_s1;
	logic [3:0] p_idx_s1;
	logic signed [DW-1:0] op_a, op_b;
	logic signed [ttb_pkg::PROD_W-1:0] prod_s1;
	logic signed [NW-1:0] prod_ext;
	logic signed [NW-1:0] acc_q;
	logic signed [NW-1:0] nums_q [7];

	logic [2:0] di_q;
	logic dstart_q;
	ttb_pkg::div_status_t dstat;
	logic [CW-1:0] res_q [ttb_pkg::COMPONENTS];
	logic deg_q;
	logic clip_q;
	logic accept;

	function automatic logic signed [DW-1:0] sub33(input logic [CW-1:0] a,
		input logic [CW-1:0] b);
		return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
	endfunction

	assign corner.ready = (state_q == ST_IDLE);
	assign accept = corner.valid && corner.ready;
	assign cc = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
	assign issue = (state_q == ST_MUL) && (mi_q <= LAST_OP);
	assign prod_ext = NW'(prod_s1);

	always_comb begin
		op_a = du1_q;
		op_b = dv2_q;
		case (mi_q)
			4'd0: begin op_a = du1_q; op_b = dv2_q; end
			4'd1: begin op_a = dv1_q; op_b = du2_q; end
			4'd2: begin op_a = e1_q[0]; op_b = dv2_q; end
			4'd3: begin op_a = e2_q[0]; op_b = dv1_q; end
			4'd4: begin op_a = e1_q[1]; op_b = dv2_q; end
			4'd5: begin op_a = e2_q[1]; op_b = dv1_q; end
			4'd6: begin op_a = e1_q[2]; op_b = dv2_q; end
			4'd7: begin op_a = e2_q[2]; op_b = dv1_q; end
			4'd8: begin op_a = e2_q[0]; op_b = du1_q; end
			4'd9: begin op_a = e1_q[0]; op_b = du2_q; end
			4'd10: begin op_a = e2_q[1]; op_b = du1_q; end
			4'd11: begin op_a = e1_q[1]; op_b = du2_q; end
			4'd12: begin op_a = e2_q[2]; op_b = du1_q; end
			4'd13: begin op_a = e1_q[2]; op_b = du2_q; end
			default: begin op_a = du1_q; op_b = dv2_q; end
		endcase
	end

	ttb_mul u_mul (
		.clk(clk),
		.a(op_a),
		.b(op_b),
		.p_s1(prod_s1)
	);

	ttb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dstart_q),
		.num(nums_q[di_q + 3'd1]),
		.den(nums_q[0]),
		.status(dstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= 2'd0;
			mi_q <= 4'd0;
			p_vld_s1 <= 1'b0;
			di_q <= 3'd0;
			dstart_q <= 1'b0;
		end else begin
			p_vld_s1 <= issue;
			dstart_q <= 1'b0;
			if (issue) begin
				mi_q <= mi_q + 4'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cc)
							2'd0: cnt_q <= 2'd1;
							2'd1: cnt_q <= 2'd2;
							default: begin
								cnt_q <= 2'd0;
								mi_q <= 4'd0;
								state_q <= ST_MUL;
							end
						endcase
					end
				end
				ST_MUL: begin
					if (p_vld_s1 && p_idx_s1 == LAST_OP) begin
						if (nums_q[0] == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
							di_q <= 3'd0;
							dstart_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (dstat.done) begin
						if (di_q == LAST_COMP) begin
							state_q <= ST_OUT;
						end else begin
							di_q <= di_q + 3'd1;
							dstart_q <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_idx_s1 <= mi_q;
		if (accept) begin
			case (cc)
				2'd0: begin
					p1_q[0] <= corner.data.pos_x;
					p1_q[1] <= corner.data.pos_y;
					p1_q[2] <= corner.data.pos_z;
					t1_q[0] <= corner.data.tex_u;
					t1_q[1] <= corner.data.tex_v;
				end
				2'd1: begin
					p2_q[0] <= corner.data.pos_x;
					p2_q[1] <= corner.data.pos_y;
					p2_q[2] <= corner.data.pos_z;
					t2_q[0] <= corner.data.tex_u;
					t2_q[1] <= corner.data.tex_v;
				end
				default: begin
					du1_q <= sub33(t2_q[0], t1_q[0]);
					dv1_q <= sub33(t2_q[1], t1_q[1]);
					du2_q <= sub33(corner.data.tex_u, t1_q[0]);
					dv2_q <= sub33(corner.data.tex_v, t1_q[1]);
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= sub33(p2_q[i], p1_q[i]);
					end
					e2_q[0] <= sub33(corner.data.pos_x, p1_q[0]);
					e2_q[1] <= sub33(corner.data.pos_y, p1_q[1]);
					e2_q[2] <= sub33(corner.data.pos_z, p1_q[2]);
				end
			endcase
		end
		if (p_vld_s1) begin
			if (!p_idx_s1[0]) begin
				acc_q <= prod_ext;
			end else begin
				nums_q[p_idx_s1[3:1]] <= acc_q - prod_ext;
			end
			if (p_idx_s1 == LAST_OP) begin
				deg_q <= (nums_q[0] == '0);
				clip_q <= 1'b0;
				for (int i = 0; i < ttb_pkg::COMPONENTS; i++) begin
					res_q[i] <= '0;
				end
			end
		end
		if (state_q == ST_DIV && dstat.done) begin
			res_q[di_q] <= dstat.quo;
			clip_q <= clip_q | dstat.clip;
		end
	end

	assign result.valid = (state_q == ST_OUT);
	assign result.data.tangent_x = res_q[0];
	assign result.data.tangent_y = res_q[1];
	assign result.data.tangent_z = res_q[2];
	assign result.data.bitangent_x = res_q[3];
	assign result.data.bitangent_y = res_q[4];
	assign result.data.bitangent_z = res_q[5];
	assign result.data.degenerate = deg_q;
	assign result.data.clipped = clip_q;

	`TTB_ASSERT(a_no_accept_while_result, result.valid |-> !corner.ready, "corner taken while result pending")
	`TTB_ASSERT(a_degenerate_zero, (result.valid && result.data.degenerate) |-> (result.data.tangent_x == '0 && result.data.bitangent_z == '0 && !result.data.clipped), "degenerate result not zero")
	`TTB_ASSERT(a_product_in_mul, p_vld_s1 |-> (state_q == ST_MUL), "product outside multiply phase")
	`TTB_ASSERT(a_div_start_in_div, dstart_q |-> (state_q == ST_DIV), "divide started outside divide phase")

endmodule
